### sv/sfda_pkg.sv
// Shared types and constants for the signed fixed-point to decimal ASCII converter.
package sfda_pkg;

    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(MAG_W);

    localparam logic [3:0] MAX_POINT   = 4'd9;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_POINT = 8'h2E;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [MAG_W-1:0] value;
        logic [3:0]              point_digits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_item_t;

    // BCD result handed from the converter to the formatter
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             neg;
        logic [3:0]       pd;
    } conv_result_t;

endpackage

### sv/sfda_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
module sfda_conv
    import sfda_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_item_t     in_data,
    output logic         res_valid,
    input  logic         res_take,
    output conv_result_t res
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } conv_state_t;

    conv_state_t          state_reg, state_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic                 neg_reg, neg_next;
    logic [3:0]           pd_reg, pd_next;
    logic [MAG_W-1:0]     raw;
    logic [BCD_W-1:0]     bcd_adj;

    function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (b[4*i +: 4] > 4'd9)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign raw     = in_data.value;
    assign bcd_adj = dd_adjust(bcd_reg);

    assign in_ready  = (state_reg == C_IDLE);
    assign res_valid = (state_reg == C_DONE);
    assign res.bcd   = bcd_reg;
    assign res.neg   = neg_reg;
    assign res.pd    = pd_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        pd_next    = pd_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = raw[MAG_W-1];
                    // most negative value wraps to its unsigned magnitude
                    mag_next   = raw[MAG_W-1] ? (~raw + {{(MAG_W-1){1'b0}}, 1'b1}) : raw;
                    pd_next    = (in_data.point_digits > MAX_POINT) ? MAX_POINT
                                                                   : in_data.point_digits;
                    bcd_next   = '0;
                    cnt_next   = '1;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
                mag_next = {mag_reg[MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                if (res_take)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        pd_reg  <= pd_next;
    end

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == C_RUN))
        else $error("accepted item did not start conversion");

    a_run_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_RUN && cnt_reg == '0) |=> (state_reg == C_DONE))
        else $error("conversion did not finish after last bit");

    a_done_digits_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (bcd_ok(bcd_reg) && pd_reg <= MAX_POINT))
        else $error("converted result holds a bad BCD digit or point position");

endmodule

### sv/sfda_fmt.sv
// Character formatter: walks the BCD digits from the top and emits sign, digits and point.
module sfda_fmt
    import sfda_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    output logic         res_take,
    input  conv_result_t res,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_data
);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_SKIP  = 5'b00010,
        F_SIGN  = 5'b00100,
        F_DIGIT = 5'b01000,
        F_POINT = 5'b10000
    } fmt_state_t;

    fmt_state_t       state_reg, state_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [3:0]       pos_reg, pos_next;
    logic [3:0]       top_reg, top_next;
    logic [3:0]       pd_reg, pd_next;
    logic             neg_reg, neg_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic             adv;
    logic [3:0]       ndig;

    // count of significant digits, at least one
    always_comb
    begin
        ndig = 4'd1;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (res.bcd[4*i +: 4] != 4'd0)
            begin
                ndig = 4'(i + 1);
            end
        end
    end

    assign adv       = !out_valid_reg || out_ready;
    assign res_take  = (state_reg == F_IDLE) && res_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        bcd_next       = bcd_reg;
        pos_next       = pos_reg;
        top_next       = top_reg;
        pd_next        = pd_reg;
        neg_next       = neg_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            F_IDLE:
            begin
                if (res_valid)
                begin
                    bcd_next   = res.bcd;
                    neg_next   = res.neg;
                    pd_next    = res.pd;
                    pos_next   = 4'(NUM_DIGITS - 1);
                    // pad so one digit stands before the point
                    top_next   = (res.pd != 4'd0 && res.pd >= ndig) ? res.pd : ndig - 4'd1;
                    state_next = F_SKIP;
                end
            end
            F_SKIP:
            begin
                if (pos_reg == top_reg)
                begin
                    state_next = neg_reg ? F_SIGN : F_DIGIT;
                end
                else
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    pos_next = pos_reg - 4'd1;
                end
            end
            F_SIGN:
            begin
                if (adv)
                begin
                    out_data_next.character = ASCII_MINUS;
                    out_data_next.last      = 1'b0;
                    out_valid_next          = 1'b1;
                    state_next              = F_DIGIT;
                end
            end
            F_DIGIT:
            begin
                if (adv)
                begin
                    out_data_next.character = ASCII_ZERO + {4'd0, bcd_reg[BCD_W-1 -: 4]};
                    out_data_next.last      = (pos_reg == 4'd0);
                    out_valid_next          = 1'b1;
                    bcd_next                = {bcd_reg[BCD_W-5:0], 4'd0};
                    pos_next                = pos_reg - 4'd1;
                    if (pos_reg == 4'd0)
                    begin
                        state_next = F_IDLE;
                    end
                    else if (pd_reg != 4'd0 && pos_reg == pd_reg)
                    begin
                        state_next = F_POINT;
                    end
                end
            end
            F_POINT:
            begin
                if (adv)
                begin
                    out_data_next.character = ASCII_POINT;
                    out_data_next.last      = 1'b0;
                    out_valid_next          = 1'b1;
                    state_next              = F_DIGIT;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg      <= bcd_next;
        pos_reg      <= pos_next;
        top_reg      <= top_next;
        pd_reg       <= pd_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIGIT && adv && pos_reg == 4'd0) |=> (state_reg == F_IDLE))
        else $error("formatter did not return to idle after the last character");

    a_point_needs_pd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_POINT) |-> (pd_reg != 4'd0 && pos_reg == pd_reg - 4'd1))
        else $error("point emitted at the wrong digit position");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.character == ASCII_MINUS) |-> !out_data_reg.last)
        else $error("minus sign flagged as last character");

endmodule

### sv/signed_fixed_point_to_decimal_ascii.sv
// Top level of the signed fixed-point to decimal ASCII converter.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_item_t  (value, point_digits)
//  out      output     out_valid / out_ready out_item_t (character, last)
//
// Each number is loaded into the bit-serial binary to BCD shifter and converted in
// 32 shift steps, one magnitude bit per step, then handed off to the formatter.
// The formatter then skips the zero digits above the top digit and emits one character
// per cycle while the output is ready (1 to 12 characters); it runs while the next
// number converts, so the shifter sets the sustained rate while the output keeps up.
// Reset clears both state machines and the output valid; no stored data needs clearing.
// A stalled output holds the formatter; the converter then waits with its result.
module signed_fixed_point_to_decimal_ascii
    import sfda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    conv_result_t res;
    logic         res_valid;
    logic         res_take;

    sfda_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    sfda_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
